// ===== rtl/rolling_mean_std_percent_b_assert.svh =====
// Assertion macros shared by the checker of the rolling mean / deviation / %B block.
// No dependencies; include by bare file name.
`ifndef ROLLING_MEAN_STD_PERCENT_B_ASSERT_SVH
`define ROLLING_MEAN_STD_PERCENT_B_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RMSB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rmsb_pkg.sv =====
// Package for the rolling mean / deviation / %B block: sizes, FSM state type,
// controller command and status structs. No dependencies.
package rmsb_pkg;

   localparam int MAX_WINDOW    = 256;
   localparam int ADDR_BITS     = $clog2(MAX_WINDOW);
   localparam int SAMPLE_BITS   = 16;
   localparam int SIZE_BITS     = 9;
   localparam int SUM_BITS      = 24;
   localparam int SQ_BITS       = 39;
   localparam int PROD_BITS     = 48;
   localparam int OUT_BITS      = 24;
   localparam int DIV_NUM_BITS  = 40;
   localparam int DIV_DEN_BITS  = 25;
   localparam int DIV_CNT_BITS  = 6;
   localparam int ROOT_OP_BITS  = 64;
   localparam int ROOT_BITS     = 32;
   localparam int ROOT_CNT_BITS = 5;
   localparam int DIFF_BITS     = 27;

   localparam logic [SIZE_BITS-1:0]    WINDOW_RESET = 9'd20;
   localparam logic [DIV_NUM_BITS-1:0] PB_POS_LIMIT = 40'd8388607;
   localparam logic [DIV_NUM_BITS-1:0] PB_NEG_LIMIT = 40'd8388608;
   localparam logic [OUT_BITS-1:0]     PB_MAX       = 24'h7FFFFF;
   localparam logic [OUT_BITS-1:0]     PB_MIN       = 24'h800000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_VAR_MUL,
      ST_VAR_SUB,
      ST_UNIT_GO,
      ST_UNIT_WAIT,
      ST_MEAN,
      ST_DEV_WAIT,
      ST_DEV,
      ST_PB_GO,
      ST_PB_WAIT,
      ST_PB,
      ST_DONE
   } rmsb_state_type;

   typedef struct packed {
      logic cfg_write;
      logic capture;
      logic square;
      logic update;
      logic var_mul;
      logic var_sub;
      logic units_go;
      logic mean_cap;
      logic dev_cap;
      logic pb_go;
      logic pb_cap;
      logic out_load;
   } rmsb_cmd_type;

   typedef struct packed {
      logic units_busy;
      logic div_busy;
      logic zero_dev;
      logic out_free;
   } rmsb_status_type;

endpackage

// ===== rtl/rmsb_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rmsb_pkg.
module rmsb_div
   import rmsb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DIV_NUM_BITS-1:0] num,
   input  logic [DIV_DEN_BITS-1:0] den,
   output logic                    busy,
   output logic [DIV_NUM_BITS-1:0] quo
);

   logic [DIV_DEN_BITS-1:0] rem_ff;
   logic [DIV_DEN_BITS-1:0] den_ff;
   logic [DIV_NUM_BITS-1:0] quo_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic                    busy_ff;
   logic [DIV_DEN_BITS:0]   rem_sh;
   logic [DIV_DEN_BITS:0]   rem_sub;
   logic                    fits;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_NUM_BITS-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      fits    = (rem_sh >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(DIV_NUM_BITS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= den;
         quo_ff <= num;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (fits) begin
            rem_ff <= rem_sub[DIV_DEN_BITS-1:0];
         end else begin
            rem_ff <= rem_sh[DIV_DEN_BITS-1:0];
         end
         quo_ff <= {quo_ff[DIV_NUM_BITS-2:0], fits};
      end
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/rmsb_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on rmsb_pkg.
module rmsb_sqrt
   import rmsb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [ROOT_OP_BITS-1:0] op,
   output logic                    busy,
   output logic [ROOT_BITS-1:0]    root
);

   logic [ROOT_OP_BITS-1:0]  rem_ff;
   logic [ROOT_OP_BITS-1:0]  res_ff;
   logic [ROOT_OP_BITS-1:0]  bit_ff;
   logic [ROOT_CNT_BITS-1:0] cnt_ff;
   logic                     busy_ff;
   logic [ROOT_OP_BITS-1:0]  trial;
   logic                     fits;

   always_comb begin
      trial = res_ff + bit_ff;
      fits  = (rem_ff >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == {ROOT_CNT_BITS{1'b1}}) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= op;
         res_ff <= '0;
         bit_ff <= ROOT_OP_BITS'(1) << (ROOT_OP_BITS - 2);
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign busy = busy_ff;
   assign root = res_ff[ROOT_BITS-1:0];

endmodule

// ===== rtl/rmsb_datapath.sv =====
// Datapath: sample ring, running sums, variance, shared divider and root unit,
// result register. Depends on rmsb_pkg, rmsb_div, rmsb_sqrt.
module rmsb_datapath
   import rmsb_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  rmsb_cmd_type                  cmd,
   output rmsb_status_type               status,
   input  logic [SIZE_BITS-1:0]          csr_window_size,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [OUT_BITS-1:0]    rsp_window_mean,
   output logic [OUT_BITS-1:0]           rsp_window_deviation,
   output logic signed [OUT_BITS-1:0]    rsp_percent_b,
   output logic                          rsp_zero_spread
);

   logic [SAMPLE_BITS-1:0]        mem [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]         vld_ff;
   logic [SIZE_BITS-1:0]          ws_ff;
   logic [ADDR_BITS-1:0]          wpos_ff;
   logic [ADDR_BITS-1:0]          pos_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [SAMPLE_BITS-1:0]        mem_q_ff;
   logic                          old_vld_ff;
   logic signed [SAMPLE_BITS-1:0] old_ff;
   logic [2*SAMPLE_BITS-2:0]      xsq_ff;
   logic [2*SAMPLE_BITS-2:0]      osq_ff;
   logic signed [SUM_BITS-1:0]    sum_ff;
   logic [SQ_BITS-1:0]            sq_ff;
   logic [PROD_BITS-1:0]          s1sq_ff;
   logic [PROD_BITS-1:0]          ns2_ff;
   logic [PROD_BITS-1:0]          var_ff;
   logic signed [OUT_BITS-1:0]    mean_ff;
   logic [OUT_BITS-1:0]           dev_ff;
   logic                          zero_ff;
   logic signed [OUT_BITS-1:0]    pb_ff;
   logic                          pb_neg_ff;
   logic                          rsp_valid_ff;
   logic signed [OUT_BITS-1:0]    rsp_mean_ff;
   logic [OUT_BITS-1:0]           rsp_dev_ff;
   logic signed [OUT_BITS-1:0]    rsp_pb_ff;
   logic                          rsp_zero_ff;

   logic [SIZE_BITS-1:0]          n_eff;
   logic [ADDR_BITS-1:0]          pos;
   logic [SIZE_BITS-1:0]          wpos_inc;
   logic [ADDR_BITS-1:0]          wpos_in;
   logic signed [SAMPLE_BITS-1:0] old_val;
   logic signed [2*SAMPLE_BITS-1:0] xsq_full;
   logic signed [2*SAMPLE_BITS-1:0] osq_full;
   logic [SUM_BITS-1:0]           abs_s1;
   logic signed [DIFF_BITS-1:0]   pb_diff;
   logic [DIFF_BITS-1:0]          pb_abs;
   logic [DIV_NUM_BITS-1:0]       div_num;
   logic [DIV_DEN_BITS-1:0]       div_den;
   logic                          div_start;
   logic                          div_busy;
   logic [DIV_NUM_BITS-1:0]       div_quo;
   logic                          sqrt_busy;
   logic [ROOT_BITS-1:0]          sqrt_root;
   logic [OUT_BITS-1:0]           q_low;

   always_comb begin
      if (ws_ff == '0) begin
         n_eff = SIZE_BITS'(1);
      end else if (ws_ff > SIZE_BITS'(MAX_WINDOW)) begin
         n_eff = SIZE_BITS'(MAX_WINDOW);
      end else begin
         n_eff = ws_ff;
      end
      pos      = ({1'b0, wpos_ff} >= n_eff) ? '0 : wpos_ff;
      wpos_inc = {1'b0, pos_ff} + 1'b1;
      wpos_in  = (wpos_inc >= n_eff) ? '0 : wpos_inc[ADDR_BITS-1:0];
      old_val  = old_vld_ff ? $signed(mem_q_ff) : '0;
      xsq_full = x_ff * x_ff;
      osq_full = old_val * old_val;
      abs_s1   = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
      pb_diff  = {{(DIFF_BITS-SAMPLE_BITS-8){x_ff[SAMPLE_BITS-1]}}, x_ff, 8'b0}
               - {{(DIFF_BITS-OUT_BITS){mean_ff[OUT_BITS-1]}}, mean_ff}
               + {{(DIFF_BITS-OUT_BITS){1'b0}}, dev_ff};
      pb_abs   = pb_diff[DIFF_BITS-1] ? DIFF_BITS'(-pb_diff) : DIFF_BITS'(pb_diff);
      q_low    = div_quo[OUT_BITS-1:0];
   end

   // one divider serves mean, deviation and %B in turn
   always_comb begin
      div_start = cmd.units_go | cmd.mean_cap | (cmd.pb_go & ~zero_ff);
      if (cmd.units_go) begin
         div_num = DIV_NUM_BITS'({abs_s1, 8'b0}) + DIV_NUM_BITS'(n_eff >> 1);
         div_den = DIV_DEN_BITS'(n_eff);
      end else if (cmd.mean_cap) begin
         div_num = DIV_NUM_BITS'(sqrt_root);
         div_den = DIV_DEN_BITS'(n_eff);
      end else begin
         div_num = DIV_NUM_BITS'({pb_abs, 12'b0}) + DIV_NUM_BITS'(dev_ff);
         div_den = {dev_ff, 1'b0};
      end
   end

   rmsb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   rmsb_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.units_go),
      .op    ({var_ff, 16'b0}),
      .busy  (sqrt_busy),
      .root  (sqrt_root)
   );

   // ring memory
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mem_q_ff <= mem[pos];
      end
      if (cmd.square) begin
         mem[pos_ff] <= x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff   <= WINDOW_RESET;
         vld_ff  <= '0;
         wpos_ff <= '0;
         sum_ff  <= '0;
         sq_ff   <= '0;
      end else if (cmd.cfg_write) begin
         ws_ff   <= csr_window_size;
         vld_ff  <= '0;
         wpos_ff <= '0;
         sum_ff  <= '0;
         sq_ff   <= '0;
      end else begin
         if (cmd.square) begin
            vld_ff[pos_ff] <= 1'b1;
         end
         if (cmd.update) begin
            sum_ff  <= sum_ff + {{(SUM_BITS-SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff}
                              - {{(SUM_BITS-SAMPLE_BITS){old_ff[SAMPLE_BITS-1]}}, old_ff};
            sq_ff   <= sq_ff + SQ_BITS'(xsq_ff) - SQ_BITS'(osq_ff);
            wpos_ff <= wpos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff       <= req_sample;
         pos_ff     <= pos;
         old_vld_ff <= vld_ff[pos];
      end
      if (cmd.square) begin
         old_ff <= old_val;
         xsq_ff <= xsq_full[2*SAMPLE_BITS-2:0];
         osq_ff <= osq_full[2*SAMPLE_BITS-2:0];
      end
      if (cmd.var_mul) begin
         s1sq_ff <= abs_s1 * abs_s1;
         ns2_ff  <= PROD_BITS'(n_eff * sq_ff);
      end
      if (cmd.var_sub) begin
         var_ff <= (ns2_ff >= s1sq_ff) ? ns2_ff - s1sq_ff : '0;
      end
      if (cmd.mean_cap) begin
         mean_ff <= sum_ff[SUM_BITS-1] ? $signed(-q_low) : $signed(q_low);
      end
      if (cmd.dev_cap) begin
         dev_ff  <= q_low;
         zero_ff <= (q_low == '0);
      end
      if (cmd.pb_go) begin
         pb_neg_ff <= pb_diff[DIFF_BITS-1];
         if (zero_ff) begin
            pb_ff <= '0;
         end
      end
      if (cmd.pb_cap) begin
         if (!pb_neg_ff) begin
            pb_ff <= (div_quo > PB_POS_LIMIT) ? PB_MAX : q_low;
         end else begin
            pb_ff <= (div_quo > PB_NEG_LIMIT) ? PB_MIN : $signed(-q_low);
         end
      end
   end

   // result register: hold while stalled, take the next result once freed
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_mean_ff <= mean_ff;
         rsp_dev_ff  <= dev_ff;
         rsp_pb_ff   <= pb_ff;
         rsp_zero_ff <= zero_ff;
      end
   end

   assign status.units_busy = div_busy | sqrt_busy;
   assign status.div_busy   = div_busy;
   assign status.zero_dev   = zero_ff;
   assign status.out_free   = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_window_mean      = rsp_mean_ff;
   assign rsp_window_deviation = rsp_dev_ff;
   assign rsp_percent_b        = rsp_pb_ff;
   assign rsp_zero_spread      = rsp_zero_ff;

endmodule

// ===== rtl/rmsb_ctrl.sv =====
// Controller state machine: sequences one sample through the datapath.
// Depends on rmsb_pkg.
module rmsb_ctrl
   import rmsb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            csr_valid,
   output logic            csr_ready,
   output rmsb_cmd_type    cmd,
   input  rmsb_status_type status
);

   rmsb_state_type state_ff;
   rmsb_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid && !csr_valid) state_in = ST_READ;
         ST_READ:      state_in = ST_UPDATE;
         ST_UPDATE:    state_in = ST_VAR_MUL;
         ST_VAR_MUL:   state_in = ST_VAR_SUB;
         ST_VAR_SUB:   state_in = ST_UNIT_GO;
         ST_UNIT_GO:   state_in = ST_UNIT_WAIT;
         ST_UNIT_WAIT: if (!status.units_busy) state_in = ST_MEAN;
         ST_MEAN:      state_in = ST_DEV_WAIT;
         ST_DEV_WAIT:  if (!status.div_busy) state_in = ST_DEV;
         ST_DEV:       state_in = ST_PB_GO;
         ST_PB_GO:     state_in = status.zero_dev ? ST_DONE : ST_PB_WAIT;
         ST_PB_WAIT:   if (!status.div_busy) state_in = ST_PB;
         ST_PB:        state_in = ST_DONE;
         ST_DONE:      if (status.out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // a window write takes the idle cycle; the sample is held off while it is pending
            req_stall     = csr_valid;
            csr_ready     = 1'b1;
            cmd.capture   = req_valid & ~csr_valid;
            cmd.cfg_write = csr_valid;
         end
         ST_READ:    cmd.square   = 1'b1;
         ST_UPDATE:  cmd.update   = 1'b1;
         ST_VAR_MUL: cmd.var_mul  = 1'b1;
         ST_VAR_SUB: cmd.var_sub  = 1'b1;
         ST_UNIT_GO: cmd.units_go = 1'b1;
         ST_MEAN:    cmd.mean_cap = 1'b1;
         ST_DEV:     cmd.dev_cap  = 1'b1;
         ST_PB_GO:   cmd.pb_go    = 1'b1;
         ST_PB:      cmd.pb_cap   = 1'b1;
         ST_DONE:    cmd.out_load = status.out_free;
         default:    cmd = '0;
      endcase
   end

endmodule

// ===== rtl/rolling_mean_std_percent_b.sv =====
// Top level of the rolling mean, population deviation and Bollinger %B block.
// Depends on rmsb_pkg, rmsb_ctrl, rmsb_datapath.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_sample (s16)
//   rsp     | out       | rsp_valid/rsp_stall  | mean s24.8, deviation u24.8, %B s24.12, zero flag
//   csr     | in        | csr_valid/csr_ready  | csr_window_size (u9)
//
// One sample at a time: a new sample is accepted only after the last result is
// loaded. Three passes of the shared 40-step divider (mean, deviation, %B) run
// in turn; the 32-step root runs alongside the mean division. A zero spread
// skips the %B division.
// Reset is synchronous and active high; window size returns to 20, the ring,
// position and sums read as zero (per-entry valid bits, cleared at once).
// A window write is taken only while idle and holds off a sample offered in
// the same cycle.
// A finished result waits in the output register under rsp_stall while the
// next sample is already accepted; the block only holds in its last step if
// the register is still full.
module rolling_mean_std_percent_b
   import rmsb_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [OUT_BITS-1:0]    rsp_window_mean,
   output logic [OUT_BITS-1:0]           rsp_window_deviation,
   output logic signed [OUT_BITS-1:0]    rsp_percent_b,
   output logic                          rsp_zero_spread,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [SIZE_BITS-1:0]          csr_window_size
);

   rmsb_cmd_type    cmd;
   rmsb_status_type status;

   // sequence: capture and read ring, square, update sums, form variance,
   // root plus mean divide, deviation divide, %B divide, load result
   rmsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic, ring storage and the output beat register
   rmsb_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_window_size      (csr_window_size),
      .req_sample           (req_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_window_mean      (rsp_window_mean),
      .rsp_window_deviation (rsp_window_deviation),
      .rsp_percent_b        (rsp_percent_b),
      .rsp_zero_spread      (rsp_zero_spread)
   );

endmodule

// ===== rtl/rmsb_checker.sv =====
// Port-level checker for the rolling mean / deviation / %B block, bound to the top.
// Depends on rmsb_pkg and rolling_mean_std_percent_b_assert.svh.
`include "rolling_mean_std_percent_b_assert.svh"

module rmsb_checker
   import rmsb_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [OUT_BITS-1:0]    rsp_window_mean,
   input logic [OUT_BITS-1:0]           rsp_window_deviation,
   input logic signed [OUT_BITS-1:0]    rsp_percent_b,
   input logic                          rsp_zero_spread,
   input logic                          csr_ready
);

   // a stalled result beat holds
   `RMSB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_percent_b) && $stable(rsp_window_mean),
      "rsp beat changed under stall")

   // zero spread forces %B and deviation to zero
   `RMSB_ASSERT_NOW(a_zero_pb, clock, reset, rsp_valid && rsp_zero_spread,
      rsp_percent_b == '0 && rsp_window_deviation == '0, "zero spread with nonzero percent B")

   // nonzero deviation never flags zero spread
   `RMSB_ASSERT_NOW(a_dev_flag, clock, reset, rsp_valid && rsp_window_deviation != '0,
      !rsp_zero_spread, "zero spread with nonzero deviation")

   // once a sample is taken, no config and no further sample next cycle
   `RMSB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall,
      !csr_ready && req_stall, "block idle right after accept")

endmodule

bind rolling_mean_std_percent_b rmsb_checker u_rmsb_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for rolling_mean_std_percent_b: directed and random samples, window sizes
// swept between phases, every result checked against an in-bench predictor. Uses rmsb_pkg.
module tb;
   import rmsb_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] mean;
      logic [OUT_BITS-1:0]        deviation;
      logic signed [OUT_BITS-1:0] pct_b;
      logic                       zero;
   } stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [OUT_BITS-1:0] rsp_window_mean;
   logic [OUT_BITS-1:0] rsp_window_deviation;
   logic signed [OUT_BITS-1:0] rsp_percent_b;
   logic rsp_zero_spread;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [SIZE_BITS-1:0] csr_window_size = '0;
   logic req_taken = 1'b0;

   rolling_mean_std_percent_b i_dut (.*);

   // Predictor state, mirrors the ring and the running sums.
   logic [SIZE_BITS-1:0] win_reg;
   longint ring [MAX_WINDOW];
   int unsigned wr_pos;
   longint sum1;
   longint unsigned sum2;

   logic signed [SAMPLE_BITS-1:0] sample_queue[$];
   stats_type stats_queue[$];
   int errors = 0;
   int beats_in = 0;
   int beats_out = 0;
   int windows_used = 0;
   longint cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic void clear_ring();
      for (int i = 0; i < MAX_WINDOW; i++) ring[i] = 0;
      wr_pos = 0;
      sum1 = 0;
      sum2 = 0;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint round_div(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   // Advance the window by one sample and return the expected stats beat.
   function automatic stats_type predict_stats(logic signed [SAMPLE_BITS-1:0] smp);
      stats_type s;
      longint x = smp;
      longint n, old, m, pb, d;
      longint unsigned sq, var_t, dev;
      n = (win_reg == 0) ? 1 : (win_reg > MAX_WINDOW ? MAX_WINDOW : win_reg);
      if (wr_pos >= n) wr_pos = 0;
      old = ring[wr_pos];
      sum1 += x - old;
      sum2 = sum2 + longint'(x * x) - longint'(old * old);
      ring[wr_pos] = x;
      wr_pos++;
      if (wr_pos >= n) wr_pos = 0;
      m = round_div(sum1 * 256, n);
      sq = (sum1 < 0) ? -sum1 : sum1;
      sq = sq * sq;
      var_t = n * sum2;
      var_t = (var_t >= sq) ? var_t - sq : 0;
      dev = int_sqrt(var_t << 16) / n;
      pb = 0;
      if (dev != 0) begin
         d = dev;
         pb = round_div((x * 256 - m + d) * 4096, 2 * d);
         if (pb > 8388607) pb = 8388607;
         if (pb < -8388608) pb = -8388608;
      end
      s.mean = m[OUT_BITS-1:0];
      s.deviation = dev[OUT_BITS-1:0];
      s.pct_b = pb[OUT_BITS-1:0];
      s.zero = (dev == 0);
      return s;
   endfunction

   // Mark the request beats the block took at this edge.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
   end

   // Driver: push queued samples with a random gap before each beat.
   int req_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            stats_queue.push_back(predict_stats(req_sample));
            beats_in++;
            req_gap = $urandom_range(6);
            if ($urandom_range(3) == 0) req_gap = 0;
         end
         if (!req_valid || req_taken) begin
            if (req_gap == 0 && sample_queue.size() > 0) begin
               req_valid <= 1'b1;
               req_sample <= sample_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
               if (req_gap > 0) req_gap--;
            end
         end
      end
   end

   // Monitor: check each result beat; drop random stalls in between.
   int rsp_hold = 0;
   always @(posedge clock) begin
      stats_type exp_s;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out++;
         if (stats_queue.size() == 0) begin
            $error("result beat with no expectation pending");
            errors++;
         end else begin
            exp_s = stats_queue.pop_front();
            if (rsp_window_mean !== exp_s.mean) begin
               $error("window_mean exp %0d got %0d", exp_s.mean, rsp_window_mean);
               errors++;
            end
            if (rsp_window_deviation !== exp_s.deviation) begin
               $error("window_deviation exp %0d got %0d", exp_s.deviation,
                      rsp_window_deviation);
               errors++;
            end
            if (rsp_percent_b !== exp_s.pct_b) begin
               $error("percent_b exp %0d got %0d", exp_s.pct_b, rsp_percent_b);
               errors++;
            end
            if (rsp_zero_spread !== exp_s.zero) begin
               $error("zero_spread exp %0d got %0d", exp_s.zero, rsp_zero_spread);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_valid && !rsp_stall) rsp_hold = $urandom_range(6);
      if (($urandom_range(7) == 0) || rsp_hold == 0) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end
   end

   // Write the window size while idle; predictor clears along with the block.
   task automatic write_window(input logic [SIZE_BITS-1:0] w);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_window_size <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      win_reg = w;
      clear_ring();
      windows_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (sample_queue.size() > 0 || stats_queue.size() > 0 || req_valid)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample(int spread);
      case ($urandom_range(9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return '0;
         default: return SAMPLE_BITS'(int'($urandom_range(2 * spread)) - spread);
      endcase
   endfunction

   initial begin
      logic [SIZE_BITS-1:0] sizes[$] = '{9'd1, 9'd2, 9'd256, 9'd0, 9'd511, 9'd3, 9'd257};
      int spread;
      win_reg = WINDOW_RESET;
      clear_ring();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, zero spread, full-scale swings at reset window.
      sample_queue = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                       16'sh0001, 16'shFFFF, 16'sh0000, 16'sh5555, 16'shAAAA};
      drain();
      write_window(9'd1);
      sample_queue = '{16'sh7FFF, 16'sh8000, 16'sh1234};
      drain();
      write_window(9'd2);
      sample_queue = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF};
      drain();
      write_window(9'd256);
      sample_queue = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF};
      drain();

      // Random phases across window sizes, extremes included.
      for (int ph = 0; ph < 14; ph++) begin
         if (ph < sizes.size()) write_window(sizes[ph]);
         else write_window(SIZE_BITS'($urandom_range(ph % 2 ? 40 : 511)));
         spread = ($urandom_range(1)) ? 32767 : $urandom_range(300);
         for (int i = 0; i < 100; i++) sample_queue.push_back(rand_sample(spread));
         drain();
      end
      write_window(WINDOW_RESET);

      $display("run covered %0d samples in, %0d results out, %0d window settings",
               beats_in, beats_out, windows_used);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
